// File: design/mlrc_pkg.sv
// Shared types, constants and lookup functions for the layer record checker.
`default_nettype none

package mlrc_pkg;

  localparam int unsigned CFG_DATA_W = 32;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned IDX_W      = 16;
  localparam int unsigned WORD_W     = 32;
  localparam int unsigned STATUS_W   = 4;
  localparam int unsigned EW_W       = 12;
  localparam int unsigned EB_W       = 6;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_BODY_BLOCKS   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SPLIT_HEAD    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_LAYERS = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_MIN    = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_HIDDEN_MAX    = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_HEADER_SIZE   = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_SIZE    = 3'd6;

  // Status codes, in check order.
  localparam logic [STATUS_W-1:0] ST_OK         = 4'd0;
  localparam logic [STATUS_W-1:0] ST_ROLE       = 4'd1;
  localparam logic [STATUS_W-1:0] ST_WEIGHTS    = 4'd2;
  localparam logic [STATUS_W-1:0] ST_BIASES     = 4'd3;
  localparam logic [STATUS_W-1:0] ST_W_RANGE    = 4'd4;
  localparam logic [STATUS_W-1:0] ST_B_RANGE    = 4'd5;
  localparam logic [STATUS_W-1:0] ST_M_RANGE    = 4'd6;
  localparam logic [STATUS_W-1:0] ST_S_RANGE    = 4'd7;
  localparam logic [STATUS_W-1:0] ST_ALIGN      = 4'd8;
  localparam logic [STATUS_W-1:0] ST_IN_SCALE   = 4'd9;
  localparam logic [STATUS_W-1:0] ST_OUT_SCALE  = 4'd10;

  // Layer geometry.
  localparam logic [IDX_W-1:0] STEM_LAYERS = 16'd6;
  localparam logic [IDX_W-1:0] HYBRID_BASE = 16'd6;

  localparam logic [EW_W-1:0] W_HYB_EVEN = 12'd288;
  localparam logic [EB_W-1:0] B_HYB_EVEN = 6'd32;
  localparam logic [EW_W-1:0] W_HYB_ODD  = 12'd512;
  localparam logic [EB_W-1:0] B_HYB_ODD  = 6'd16;
  localparam logic [EW_W-1:0] W_LINEAR   = 12'd160;
  localparam logic [EB_W-1:0] B_LINEAR   = 6'd5;
  localparam logic [EW_W-1:0] W_HIDDEN   = 12'd1024;
  localparam logic [EB_W-1:0] B_HIDDEN   = 6'd32;
  localparam logic [EW_W-1:0] W_OBJ      = 12'd32;
  localparam logic [EB_W-1:0] B_OBJ      = 6'd1;
  localparam logic [EW_W-1:0] W_BOX      = 12'd128;
  localparam logic [EB_W-1:0] B_BOX      = 6'd4;

  localparam logic [WORD_W-1:0] SCALE_INF_BITS = 32'h7F80_0000;

  // Reset values of the configuration registers.
  localparam logic [7:0]        RST_BODY_BLOCKS   = 8'd1;
  localparam logic              RST_SPLIT_HEAD    = 1'b0;
  localparam logic [7:0]        RST_HIDDEN_LAYERS = 8'd0;
  localparam logic [7:0]        RST_HIDDEN_MIN    = 8'd1;
  localparam logic [7:0]        RST_HIDDEN_MAX    = 8'd4;
  localparam logic [15:0]       RST_HEADER_SIZE   = 16'd0;
  localparam logic [WORD_W-1:0] RST_IMAGE_SIZE    = 32'd0;

  typedef struct packed {
    logic [7:0]        body_blocks;
    logic              split_head;
    logic [7:0]        hidden_layers;
    logic [7:0]        hidden_min;
    logic [7:0]        hidden_max;
    logic [15:0]       header_size;
    logic [WORD_W-1:0] image_size;
  } mlrc_cfg_t;

  typedef struct packed {
    logic            found;
    logic [EW_W-1:0] weights;
    logic [EB_W-1:0] biases;
  } mlrc_role_t;

  typedef struct packed {
    logic [IDX_W-1:0]  layer_index;
    logic [WORD_W-1:0] weight_total;
    logic [WORD_W-1:0] bias_total;
    logic [WORD_W-1:0] weight_base;
    logic [WORD_W-1:0] bias_base;
    logic [WORD_W-1:0] mult_base;
    logic [WORD_W-1:0] shift_base;
    logic [WORD_W-1:0] input_scale_bits;
    logic [WORD_W-1:0] output_scale_bits;
  } mlrc_item_t;

  function automatic logic [EW_W-1:0] stem_weights(input logic [2:0] idx);
    logic [EW_W-1:0] w;
    case (idx)
      3'd0, 3'd1: w = 12'd36;
      3'd2, 3'd3: w = 12'd576;
      3'd4, 3'd5: w = 12'd2304;
      default:    w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [EB_W-1:0] stem_biases(input logic [2:0] idx);
    logic [EB_W-1:0] b;
    case (idx)
      3'd0, 3'd1: b = 6'd4;
      3'd2, 3'd3: b = 6'd8;
      3'd4, 3'd5: b = 6'd16;
      default:    b = '0;
    endcase
    return b;
  endfunction

endpackage

`default_nettype wire

// File: design/mlrc_if.sv
// Valid/ready channel interfaces for layer records and check results.
`default_nettype none

interface mlrc_req_if import mlrc_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [IDX_W-1:0]  layer_index;
  logic [WORD_W-1:0] weight_total;
  logic [WORD_W-1:0] bias_total;
  logic [WORD_W-1:0] weight_base;
  logic [WORD_W-1:0] bias_base;
  logic [WORD_W-1:0] mult_base;
  logic [WORD_W-1:0] shift_base;
  logic [WORD_W-1:0] input_scale_bits;
  logic [WORD_W-1:0] output_scale_bits;

  modport source (
    output valid, layer_index, weight_total, bias_total, weight_base, bias_base,
           mult_base, shift_base, input_scale_bits, output_scale_bits,
    input  ready
  );
  modport sink (
    input  valid, layer_index, weight_total, bias_total, weight_base, bias_base,
           mult_base, shift_base, input_scale_bits, output_scale_bits,
    output ready
  );
endinterface

interface mlrc_res_if import mlrc_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [STATUS_W-1:0] status_code;
  logic [EW_W-1:0]     needed_weights;
  logic [EB_W-1:0]     expected_biases;

  modport source (output valid, status_code, needed_weights, expected_biases, input ready);
  modport sink   (input valid, status_code, needed_weights, expected_biases, output ready);
endinterface

`default_nettype wire

// File: design/mlrc_role.sv
// Role decoder: expected weight and bias counts for a layer index.
`default_nettype none

module mlrc_role import mlrc_pkg::*; (
  input  wire logic [IDX_W-1:0] layer_index,
  input  wire mlrc_cfg_t        cfg,
  output mlrc_role_t            role
);

  logic [IDX_W-1:0] head;
  logic [IDX_W-1:0] obj;
  logic             hidden_ok;

  // The head starts right after four roles per hybrid block.
  assign head      = HYBRID_BASE + {6'd0, cfg.body_blocks, 2'b00};
  assign obj       = head + {8'd0, cfg.hidden_layers};
  assign hidden_ok = (cfg.hidden_layers >= cfg.hidden_min) &&
                     (cfg.hidden_layers <= cfg.hidden_max);

  always_comb begin
    role = '0;
    if (layer_index < STEM_LAYERS) begin
      role.found   = 1'b1;
      role.weights = stem_weights(layer_index[2:0]);
      role.biases  = stem_biases(layer_index[2:0]);
    end else if (layer_index < head) begin
      role.found = 1'b1;
      // The base index is even, so bit 0 gives the parity within the body.
      if (!layer_index[0]) begin
        role.weights = W_HYB_EVEN;
        role.biases  = B_HYB_EVEN;
      end else begin
        role.weights = W_HYB_ODD;
        role.biases  = B_HYB_ODD;
      end
    end else if (!cfg.split_head) begin
      if (layer_index == head) begin
        role.found   = 1'b1;
        role.weights = W_LINEAR;
        role.biases  = B_LINEAR;
      end
    end else if (hidden_ok) begin
      if (layer_index < obj) begin
        role.found   = 1'b1;
        role.weights = W_HIDDEN;
        role.biases  = B_HIDDEN;
      end else if (layer_index == obj) begin
        role.found   = 1'b1;
        role.weights = W_OBJ;
        role.biases  = B_OBJ;
      end else if (layer_index == obj + 16'd1) begin
        role.found   = 1'b1;
        role.weights = W_BOX;
        role.biases  = B_BOX;
      end
    end
  end

endmodule

`default_nettype wire

// File: design/mlrc_check.sv
// Record checks: counts, offset ranges, alignment and scale positivity, first failure wins.
`default_nettype none

module mlrc_check import mlrc_pkg::*; (
  input  wire mlrc_item_t           item,
  input  wire mlrc_cfg_t            cfg,
  input  wire mlrc_role_t           role,
  output logic [STATUS_W-1:0]       status_code
);

  logic [WORD_W-1:0] header_ext;
  logic [WORD_W-1:0] w_len;
  logic [WORD_W-1:0] b_len;
  logic              w_span_ok;
  logic              b_span_ok;
  logic              m_span_ok;
  logic              s_span_ok;
  logic              aligned;

  function automatic logic span_ok(input logic [WORD_W-1:0] off,
                                   input logic [WORD_W-1:0] len,
                                   input logic [WORD_W-1:0] hdr,
                                   input logic [WORD_W-1:0] img);
    logic ok;
    ok = (off >= hdr) && (off <= img) && (len <= img - off);
    return ok;
  endfunction

  function automatic logic scale_pos(input logic [WORD_W-1:0] bits);
    return (bits != '0) && (bits <= SCALE_INF_BITS);
  endfunction

  assign header_ext = {16'd0, cfg.header_size};
  assign w_len      = {20'd0, role.weights};
  // Biases, multipliers and shifts are four bytes each.
  assign b_len      = {24'd0, role.biases, 2'b00};

  assign w_span_ok = span_ok(item.weight_base, w_len, header_ext, cfg.image_size);
  assign b_span_ok = span_ok(item.bias_base, b_len, header_ext, cfg.image_size);
  assign m_span_ok = span_ok(item.mult_base, b_len, header_ext, cfg.image_size);
  assign s_span_ok = span_ok(item.shift_base, b_len, header_ext, cfg.image_size);

  assign aligned = (item.weight_base[3:0] == 4'd0) &&
                   (item.bias_base[1:0] == 2'd0) &&
                   (item.mult_base[1:0] == 2'd0) &&
                   (item.shift_base[1:0] == 2'd0);

  always_comb begin
    if (!role.found) begin
      status_code = ST_ROLE;
    end else if (item.weight_total != w_len) begin
      status_code = ST_WEIGHTS;
    end else if (item.bias_total != {26'd0, role.biases}) begin
      status_code = ST_BIASES;
    end else if (!w_span_ok) begin
      status_code = ST_W_RANGE;
    end else if (!b_span_ok) begin
      status_code = ST_B_RANGE;
    end else if (!m_span_ok) begin
      status_code = ST_M_RANGE;
    end else if (!s_span_ok) begin
      status_code = ST_S_RANGE;
    end else if (!aligned) begin
      status_code = ST_ALIGN;
    end else if (!scale_pos(item.input_scale_bits)) begin
      status_code = ST_IN_SCALE;
    end else if (!scale_pos(item.output_scale_bits)) begin
      status_code = ST_OUT_SCALE;
    end else begin
      status_code = ST_OK;
    end
  end

endmodule

`default_nettype wire

// File: design/model_layer_record_checker_unit.sv
// A request in the input stage enters the result register when that is empty or read.
// Throughput: one request per cycle, limited only by the result side taking results.
// The input register and the result register form a two-stage pipeline with
// per-stage valid bits, so one request can wait in the input stage while a result stalls.
// Reset (rst, synchronous, active high) empties both stages and loads the
// configuration registers with their defaults.
`default_nettype none

module model_layer_record_checker_unit import mlrc_pkg::*; (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  cfg_wr_en,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_data,
  mlrc_req_if.sink                   request,
  mlrc_res_if.source                 result
);

  mlrc_cfg_t           cfg;
  logic                stage_valid;
  mlrc_item_t          stage_item;
  logic                res_valid;
  logic [STATUS_W-1:0] res_status;
  logic [EW_W-1:0]     res_weights;
  logic [EB_W-1:0]     res_biases;
  logic                advance;
  mlrc_role_t          role;
  logic [STATUS_W-1:0] status_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.body_blocks   <= RST_BODY_BLOCKS;
      cfg.split_head    <= RST_SPLIT_HEAD;
      cfg.hidden_layers <= RST_HIDDEN_LAYERS;
      cfg.hidden_min    <= RST_HIDDEN_MIN;
      cfg.hidden_max    <= RST_HIDDEN_MAX;
      cfg.header_size   <= RST_HEADER_SIZE;
      cfg.image_size    <= RST_IMAGE_SIZE;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        REG_BODY_BLOCKS:   cfg.body_blocks   <= cfg_data[7:0];
        REG_SPLIT_HEAD:    cfg.split_head    <= cfg_data[0];
        REG_HIDDEN_LAYERS: cfg.hidden_layers <= cfg_data[7:0];
        REG_HIDDEN_MIN:    cfg.hidden_min    <= cfg_data[7:0];
        REG_HIDDEN_MAX:    cfg.hidden_max    <= cfg_data[7:0];
        REG_HEADER_SIZE:   cfg.header_size   <= cfg_data[15:0];
        REG_IMAGE_SIZE:    cfg.image_size    <= cfg_data[WORD_W-1:0];
        default: begin
        end
      endcase
    end
  end

  // The input stage moves on whenever the result register is empty or being read.
  assign advance       = !res_valid || result.ready;
  assign request.ready = !stage_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      stage_valid <= 1'b0;
    end else if (request.ready) begin
      stage_valid <= request.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (request.valid && request.ready) begin
      stage_item.layer_index       <= request.layer_index;
      stage_item.weight_total      <= request.weight_total;
      stage_item.bias_total        <= request.bias_total;
      stage_item.weight_base       <= request.weight_base;
      stage_item.bias_base         <= request.bias_base;
      stage_item.mult_base         <= request.mult_base;
      stage_item.shift_base        <= request.shift_base;
      stage_item.input_scale_bits  <= request.input_scale_bits;
      stage_item.output_scale_bits <= request.output_scale_bits;
    end
  end

  mlrc_role u_role (
    .layer_index (stage_item.layer_index),
    .cfg         (cfg),
    .role        (role)
  );

  mlrc_check u_check (
    .item        (stage_item),
    .cfg         (cfg),
    .role        (role),
    .status_code (status_next)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= stage_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && stage_valid) begin
      res_status  <= status_next;
      res_weights <= role.weights;
      res_biases  <= role.biases;
    end
  end

  assign result.valid           = res_valid;
  assign result.status_code     = res_status;
  assign result.needed_weights  = res_weights;
  assign result.expected_biases = res_biases;

endmodule

`default_nettype wire

// File: test/testbench.sv
// Self-checking testbench for the layer record checker, with a built-in predictor.
`timescale 1ns / 100ps

module testbench;
  import mlrc_pkg::*;

  localparam int unsigned HOLD_CYCLES  = 200;
  localparam int unsigned TAIL_CYCLES  = 4;
  localparam int unsigned LIMIT_CYCLES = 200000;

  typedef struct packed {
    logic        found;
    logic [31:0] weights;
    logic [31:0] biases;
  } layer_shape_t;

  typedef struct packed {
    logic [STATUS_W-1:0] status;
    logic [EW_W-1:0]     weights;
    logic [EB_W-1:0]     biases;
  } record_verdict_t;

  logic                  clk;
  logic                  rst;
  logic                  cfg_wr_en;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  mlrc_req_if req_ch ();
  mlrc_res_if res_ch ();

  model_layer_record_checker_unit dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .request   (req_ch),
    .result    (res_ch)
  );

  // Our own copy of the architecture registers.
  logic [31:0] arch_body_blocks;
  logic        arch_split_head;
  logic [31:0] arch_hidden_layers;
  logic [31:0] arch_hidden_min;
  logic [31:0] arch_hidden_max;
  logic [31:0] image_header_bytes;
  logic [31:0] image_bytes;

  record_verdict_t verdict_queue[$];
  int              mismatches = 0;
  int              cycle_count = 0;
  bit              sender_idles = 1'b1;
  bit              receiver_stalls = 1'b1;
  int              holds_asked = 0;
  int              holds_served = 0;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  // ---------------------------------------------------------------- predictor

  function automatic layer_shape_t layer_shape(input logic [31:0] idx);
    layer_shape_t s;
    logic [31:0]  head;
    logic [31:0]  obj;
    head = 32'd6 + 32'd4 * arch_body_blocks;
    obj  = head + arch_hidden_layers;
    s    = '0;
    if (idx < 32'd6) begin
      s.found = 1'b1;
      case (idx[2:0])
        3'd0, 3'd1: begin s.weights = 32'd36;   s.biases = 32'd4;  end
        3'd2, 3'd3: begin s.weights = 32'd576;  s.biases = 32'd8;  end
        default:    begin s.weights = 32'd2304; s.biases = 32'd16; end
      endcase
    end else if (idx < head) begin
      s.found = 1'b1;
      if (((idx - 32'd6) & 32'd1) == 32'd0) begin
        s.weights = 32'd9 * 32'd32;
        s.biases  = 32'd32;
      end else begin
        s.weights = 32'd32 * 32'd16;
        s.biases  = 32'd16;
      end
    end else if (!arch_split_head) begin
      if (idx == head) begin
        s.found   = 1'b1;
        s.weights = 32'd32 * 32'd5;
        s.biases  = 32'd5;
      end
    end else if (arch_hidden_layers >= arch_hidden_min &&
                 arch_hidden_layers <= arch_hidden_max) begin
      if (idx < obj) begin
        s.found   = 1'b1;
        s.weights = 32'd32 * 32'd32;
        s.biases  = 32'd32;
      end else if (idx == obj) begin
        s.found   = 1'b1;
        s.weights = 32'd32;
        s.biases  = 32'd1;
      end else if (idx == obj + 32'd1) begin
        s.found   = 1'b1;
        s.weights = 32'd32 * 32'd4;
        s.biases  = 32'd4;
      end
    end
    return s;
  endfunction

  function automatic logic span_fits(input logic [31:0] off, input logic [31:0] len);
    return off >= image_header_bytes && off <= image_bytes && len <= image_bytes - off;
  endfunction

  // Sign clear, not zero, not NaN: +inf and positive denormals pass.
  function automatic logic scale_positive(input logic [31:0] bits);
    return bits != 32'd0 && bits <= 32'h7F80_0000;
  endfunction

  function automatic record_verdict_t predict_verdict(input mlrc_item_t it);
    layer_shape_t    s;
    logic [31:0]     blen;
    record_verdict_t v;
    s         = layer_shape({16'd0, it.layer_index});
    blen      = s.biases * 32'd4;
    v.weights = s.weights[EW_W-1:0];
    v.biases  = s.biases[EB_W-1:0];
    if (!s.found) begin
      v.status  = ST_ROLE;
      v.weights = '0;
      v.biases  = '0;
    end else if (it.weight_total != s.weights) begin
      v.status = ST_WEIGHTS;
    end else if (it.bias_total != s.biases) begin
      v.status = ST_BIASES;
    end else if (!span_fits(it.weight_base, s.weights)) begin
      v.status = ST_W_RANGE;
    end else if (!span_fits(it.bias_base, blen)) begin
      v.status = ST_B_RANGE;
    end else if (!span_fits(it.mult_base, blen)) begin
      v.status = ST_M_RANGE;
    end else if (!span_fits(it.shift_base, blen)) begin
      v.status = ST_S_RANGE;
    end else if (it.weight_base[3:0] != 4'd0 || it.bias_base[1:0] != 2'd0 ||
                 it.mult_base[1:0] != 2'd0 || it.shift_base[1:0] != 2'd0) begin
      v.status = ST_ALIGN;
    end else if (!scale_positive(it.input_scale_bits)) begin
      v.status = ST_IN_SCALE;
    end else if (!scale_positive(it.output_scale_bits)) begin
      v.status = ST_OUT_SCALE;
    end else begin
      v.status = ST_OK;
    end
    return v;
  endfunction

  // ------------------------------------------------------------ record makers

  function automatic logic [31:0] last_valid_index();
    logic [31:0] head;
    head = 32'd6 + 32'd4 * arch_body_blocks;
    if (!arch_split_head) return head;
    if (arch_hidden_layers < arch_hidden_min || arch_hidden_layers > arch_hidden_max)
      return head - 32'd1;
    return head + arch_hidden_layers + 32'd1;
  endfunction

  function automatic logic [15:0] pick_index();
    logic [31:0] last;
    logic [31:0] idx;
    last = last_valid_index();
    case ($urandom_range(0, 3))
      0:       idx = $urandom_range(0, 5);
      1:       idx = last - $urandom_range(0, 3);
      default: idx = $urandom_range(0, last);
    endcase
    return idx[15:0];
  endfunction

  // An aligned offset inside the payload, often right at either end of the room.
  function automatic logic [31:0] pick_offset(input logic [31:0] len, input logic [31:0] align);
    logic [31:0] lo;
    logic [31:0] hi;
    lo = (image_header_bytes + align - 32'd1) & ~(align - 32'd1);
    if (image_bytes < len || image_bytes - len < lo) return lo;
    hi = (image_bytes - len) & ~(align - 32'd1);
    case ($urandom_range(0, 7))
      0:       return lo;
      1:       return hi;
      default: return lo + align * $urandom_range(0, (hi - lo) / align);
    endcase
  endfunction

  function automatic logic [31:0] good_scale();
    case ($urandom_range(0, 5))
      0:       return $urandom_range(1, 32'h007F_FFFF);
      1:       return 32'h7F80_0000;
      2:       return 32'd1;
      default: return $urandom_range(32'h0080_0000, 32'h7F7F_FFFF);
    endcase
  endfunction

  function automatic logic [31:0] bad_scale();
    case ($urandom_range(0, 5))
      0:       return 32'd0;
      1:       return 32'h8000_0000;
      2:       return 32'h8000_0000 | $urandom;
      3:       return 32'h7F80_0001 + $urandom_range(0, 32'h007F_FFFE);
      4:       return 32'hFFFF_FFFF;
      default: return 32'h7FC0_0000;
    endcase
  endfunction

  function automatic logic [31:0] bad_offset(input logic [31:0] len);
    case ($urandom_range(0, 2))
      0: begin
        if (image_header_bytes != 32'd0) return $urandom_range(0, image_header_bytes - 32'd1);
        return image_bytes - len + 32'd4;
      end
      1:       return image_bytes - len + 32'd4;
      default: return $urandom;
    endcase
  endfunction

  function automatic mlrc_item_t well_formed(input logic [15:0] idx);
    mlrc_item_t   it;
    layer_shape_t s;
    s                    = layer_shape({16'd0, idx});
    it.layer_index       = idx;
    it.weight_total      = s.weights;
    it.bias_total        = s.biases;
    it.weight_base       = pick_offset(s.weights, 32'd16);
    it.bias_base         = pick_offset(s.biases * 32'd4, 32'd4);
    it.mult_base         = pick_offset(s.biases * 32'd4, 32'd4);
    it.shift_base        = pick_offset(s.biases * 32'd4, 32'd4);
    it.input_scale_bits  = good_scale();
    it.output_scale_bits = good_scale();
    return it;
  endfunction

  // Spoils one aspect of a well-formed record so that a given check trips.
  function automatic mlrc_item_t spoil_record(input mlrc_item_t it);
    layer_shape_t s;
    logic [31:0]  blen;
    logic [31:0]  idx;
    s    = layer_shape({16'd0, it.layer_index});
    blen = s.biases * 32'd4;
    case ($urandom_range(0, 9))
      0: begin
        idx = ($urandom_range(0, 1) == 0) ? last_valid_index() + $urandom_range(1, 3) : $urandom;
        it.layer_index = idx[15:0];
      end
      1:       it.weight_total = it.weight_total ^ (32'd1 << $urandom_range(0, 31));
      2:       it.bias_total = it.bias_total ^ (32'd1 << $urandom_range(0, 31));
      3:       it.weight_base = bad_offset(s.weights);
      4:       it.bias_base = bad_offset(blen);
      5:       it.mult_base = bad_offset(blen);
      6:       it.shift_base = bad_offset(blen);
      7: begin
        case ($urandom_range(0, 3))
          0:       it.weight_base = it.weight_base + $urandom_range(1, 15);
          1:       it.bias_base = it.bias_base + $urandom_range(1, 3);
          2:       it.mult_base = it.mult_base + $urandom_range(1, 3);
          default: it.shift_base = it.shift_base + $urandom_range(1, 3);
        endcase
      end
      8:       it.input_scale_bits = bad_scale();
      default: it.output_scale_bits = bad_scale();
    endcase
    return it;
  endfunction

  function automatic mlrc_item_t random_record();
    mlrc_item_t  it;
    int unsigned roll;
    roll = $urandom_range(0, 99);
    if (roll < 5) begin
      it.layer_index       = 16'($urandom);
      it.weight_total      = $urandom;
      it.bias_total        = $urandom;
      it.weight_base       = $urandom;
      it.bias_base         = $urandom;
      it.mult_base         = $urandom;
      it.shift_base        = $urandom;
      it.input_scale_bits  = $urandom;
      it.output_scale_bits = $urandom;
    end else begin
      it = well_formed(pick_index());
      if (roll < 40) it = spoil_record(it);
    end
    return it;
  endfunction

  // ------------------------------------------------------------- bus drivers

  // Valid stays high after an accepted request so that back-to-back requests
  // need no second assignment in the same step; it drops on an idle cycle.
  task automatic send_record(input mlrc_item_t it);
    while (sender_idles && $urandom_range(0, 99) < 28) begin
      req_ch.valid <= 1'b0;
      @(posedge clk);
    end
    req_ch.valid             <= 1'b1;
    req_ch.layer_index       <= it.layer_index;
    req_ch.weight_total      <= it.weight_total;
    req_ch.bias_total        <= it.bias_total;
    req_ch.weight_base       <= it.weight_base;
    req_ch.bias_base         <= it.bias_base;
    req_ch.mult_base         <= it.mult_base;
    req_ch.shift_base        <= it.shift_base;
    req_ch.input_scale_bits  <= it.input_scale_bits;
    req_ch.output_scale_bits <= it.output_scale_bits;
    @(posedge clk);
    while (req_ch.ready !== 1'b1) @(posedge clk);
    verdict_queue.push_back(predict_verdict(it));
  endtask

  task automatic send_random(input int count);
    repeat (count) send_record(random_record());
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (verdict_queue.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
  endtask

  task automatic set_arch(input logic [7:0] hybrid, input logic mlp, input logic [7:0] hidden,
                          input logic [7:0] hmin, input logic [7:0] hmax,
                          input logic [15:0] header, input logic [31:0] total);
    write_reg(REG_BODY_BLOCKS, {24'd0, hybrid});
    write_reg(REG_SPLIT_HEAD, {31'd0, mlp});
    write_reg(REG_HIDDEN_LAYERS, {24'd0, hidden});
    write_reg(REG_HIDDEN_MIN, {24'd0, hmin});
    write_reg(REG_HIDDEN_MAX, {24'd0, hmax});
    write_reg(REG_HEADER_SIZE, {16'd0, header});
    write_reg(REG_IMAGE_SIZE, total);
    cfg_wr_en <= 1'b0;
    @(posedge clk);
    arch_body_blocks   = {24'd0, hybrid};
    arch_split_head    = mlp;
    arch_hidden_layers = {24'd0, hidden};
    arch_hidden_min    = {24'd0, hmin};
    arch_hidden_max    = {24'd0, hmax};
    image_header_bytes = {16'd0, header};
    image_bytes        = total;
  endtask

  task automatic random_arch();
    logic [7:0]  hybrid;
    logic        mlp;
    logic [7:0]  hidden;
    logic [7:0]  hmin;
    logic [7:0]  hmax;
    logic [15:0] header;
    logic [31:0] total;
    case ($urandom_range(0, 3))
      0:       hybrid = 8'd0;
      1:       hybrid = 8'd255;
      default: hybrid = 8'($urandom_range(1, 6));
    endcase
    mlp    = 1'($urandom_range(0, 1));
    hmin   = 8'($urandom_range(0, 3));
    hmax   = hmin + 8'($urandom_range(0, 4));
    hidden = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(hmin, hmax));
    header = 16'($urandom);
    total  = ($urandom_range(0, 4) == 0) ? 32'hFFFF_FFFF
                                         : {16'd0, header} + $urandom_range(4096, 32'h0010_0000);
    set_arch(hybrid, mlp, hidden, hmin, hmax, header, total);
  endtask

  // -------------------------------------------------------- result side

  initial begin
    res_ch.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (holds_served != holds_asked) begin
        holds_served = holds_asked;
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end else if (receiver_stalls && $urandom_range(0, 99) < 28) begin
        res_ch.ready <= 1'b0;
      end else begin
        res_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : check_results
    record_verdict_t want;
    if (!rst && res_ch.valid === 1'b1 && res_ch.ready === 1'b1) begin
      if (verdict_queue.size() == 0) begin
        $display("%0t: result with none expected, status %0d", $time, res_ch.status_code);
        mismatches++;
      end else begin
        want = verdict_queue.pop_front();
        if (res_ch.status_code !== want.status) begin
          $display("%0t: status_code expected %0d got %0d", $time, want.status,
                   res_ch.status_code);
          mismatches++;
        end
        if (res_ch.needed_weights !== want.weights) begin
          $display("%0t: needed_weights expected %0d got %0d", $time, want.weights,
                   res_ch.needed_weights);
          mismatches++;
        end
        if (res_ch.expected_biases !== want.biases) begin
          $display("%0t: expected_biases expected %0d got %0d", $time, want.biases,
                   res_ch.expected_biases);
          mismatches++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_reset_defaults();
    send_record(well_formed(16'd7));
    send_record(well_formed(16'd10));
    send_record(well_formed(16'd11));
  endtask

  task automatic test_record_checks();
    mlrc_item_t r;
    wait_drained();
    set_arch(8'd2, 1'b0, 8'd0, 8'd1, 8'd4, 16'd64, 32'd65536);
    send_record(well_formed(16'd0));
    send_record(well_formed(16'd5));
    send_record(well_formed(16'd6));
    send_record(well_formed(16'd13));
    send_record(well_formed(16'd14));
    send_record(well_formed(16'd15));
    r = '1;
    send_record(r);
    r = '0;
    send_record(r);
    r = well_formed(16'd2);
    r.weight_total = 32'd577;
    send_record(r);
    r = well_formed(16'd3);
    r.bias_total = 32'd9;
    send_record(r);
    // Weights that end exactly at the image end pass; one block further fails.
    r = well_formed(16'd4);
    r.weight_base = 32'd65536 - 32'd2304;
    send_record(r);
    r.weight_base = 32'd65536 - 32'd2304 + 32'd16;
    send_record(r);
    r = well_formed(16'd1);
    r.weight_base = 32'd48;
    send_record(r);
    r = well_formed(16'd1);
    r.bias_base = 32'd65540;
    send_record(r);
    r = well_formed(16'd0);
    r.mult_base = 32'd65524;
    send_record(r);
    r = well_formed(16'd0);
    r.shift_base = 32'd0;
    send_record(r);
    r = well_formed(16'd0);
    r.weight_base = 32'd68;
    send_record(r);
    r = well_formed(16'd6);
    r.input_scale_bits = 32'd0;
    send_record(r);
    r.input_scale_bits = 32'h8000_0000;
    send_record(r);
    r = well_formed(16'd7);
    r.output_scale_bits = 32'h7FC0_0000;
    send_record(r);
    r.output_scale_bits = 32'h7F80_0001;
    send_record(r);
    r.input_scale_bits  = 32'd1;
    r.output_scale_bits = 32'h7F80_0000;
    send_record(r);
  endtask

  task automatic test_split_head();
    wait_drained();
    set_arch(8'd3, 1'b1, 8'd2, 8'd1, 8'd4, 16'd256, 32'd200000);
    send_random(60);
  endtask

  task automatic test_hidden_out_of_range();
    wait_drained();
    set_arch(8'd3, 1'b1, 8'd6, 8'd1, 8'd4, 16'd256, 32'd200000);
    send_random(25);
    wait_drained();
    set_arch(8'd1, 1'b1, 8'd0, 8'd255, 8'd0, 16'd16, 32'd70000);
    send_random(20);
  endtask

  task automatic test_extreme_arch();
    wait_drained();
    set_arch(8'd255, 1'b1, 8'd255, 8'd0, 8'd255, 16'hFFFF, 32'hFFFF_FFFF);
    send_random(50);
    wait_drained();
    set_arch(8'd0, 1'b0, 8'd0, 8'd0, 8'd0, 16'd0, 32'd8192);
    send_random(30);
  endtask

  task automatic test_random_archs();
    repeat (4) begin
      wait_drained();
      random_arch();
      send_random(25);
      // Sender holds back until every result so far is in.
      wait_drained();
      send_random(20);
    end
  endtask

  task automatic test_back_pressure();
    wait_drained();
    random_arch();
    sender_idles = 1'b0;
    holds_asked++;
    send_random(40);
    sender_idles = 1'b1;
  endtask

  task automatic test_no_idling();
    wait_drained();
    set_arch(8'd4, 1'b1, 8'd3, 8'd2, 8'd3, 16'd1024, 32'h0004_0000);
    sender_idles    = 1'b0;
    receiver_stalls = 1'b0;
    send_random(60);
    sender_idles    = 1'b1;
    receiver_stalls = 1'b1;
  endtask

  initial begin
    arch_body_blocks   = 32'd1;
    arch_split_head    = 1'b0;
    arch_hidden_layers = 32'd0;
    arch_hidden_min    = 32'd1;
    arch_hidden_max    = 32'd4;
    image_header_bytes = 32'd0;
    image_bytes        = 32'd0;
    rst                      <= 1'b1;
    cfg_wr_en                <= 1'b0;
    cfg_index                <= '0;
    cfg_data                 <= '0;
    req_ch.valid             <= 1'b0;
    req_ch.layer_index       <= '0;
    req_ch.weight_total      <= '0;
    req_ch.bias_total        <= '0;
    req_ch.weight_base       <= '0;
    req_ch.bias_base         <= '0;
    req_ch.mult_base         <= '0;
    req_ch.shift_base        <= '0;
    req_ch.input_scale_bits  <= '0;
    req_ch.output_scale_bits <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_reset_defaults();
    test_record_checks();
    test_split_head();
    test_hidden_out_of_range();
    test_extreme_arch();
    test_random_archs();
    test_back_pressure();
    test_no_idling();
    wait_drained();

    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

// File: files.f
design/mlrc_pkg.sv
design/mlrc_if.sv
design/mlrc_role.sv
design/mlrc_check.sv
design/model_layer_record_checker_unit.sv
test/testbench.sv
